/* rtl/core/stt_pkg.sv */
// Package for the software timer table: sizes, command and result codes,
// and the item and control types shared by the top level and the arithmetic unit.
// Depends on nothing.
package stt_pkg;

    // Table size and limits.
    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Configuration register.
    localparam int          CPM_W     = 20;
    localparam logic [19:0] CPM_RESET = 20'd160000;

    // Opcodes.
    localparam logic [3:0] OP_INIT    = 4'd0;
    localparam logic [3:0] OP_DEINIT  = 4'd1;
    localparam logic [3:0] OP_CREATE  = 4'd2;
    localparam logic [3:0] OP_DELETE  = 4'd3;
    localparam logic [3:0] OP_SET     = 4'd4;
    localparam logic [3:0] OP_SET_PER = 4'd5;
    localparam logic [3:0] OP_UNSET   = 4'd6;
    localparam logic [3:0] OP_SUSPEND = 4'd7;
    localparam logic [3:0] OP_RESUME  = 4'd8;
    localparam logic [3:0] OP_TICK    = 4'd9;

    // Result kinds.
    localparam logic [1:0] KIND_REPLY  = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;

    // One command item.
    typedef struct packed {
        logic [3:0]  opcode;
        logic [3:0]  slot;
        logic [31:0] duration_ms;
        logic        resume_flag;
        logic [63:0] now_cycles;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic       ok;
        logic [3:0] slot_out;
        logic       prior_flag;
        logic       last;
    } t_res;

    // One entry of the timing memory.
    typedef struct packed {
        logic [63:0] expiration;
        logic [63:0] period;
    } t_entry;

    // Control of the shared arithmetic unit.
    typedef struct packed {
        logic mul_en;
        logic sub;
    } t_alu_ctl;

endpackage

/* rtl/core/software_timer_table_top.sv */
// Top level of the software timer table: command sequencer, slot flags,
// timing memory and result register. Depends on stt_pkg and stt_arith.
//
//  Channel  | Ports                              | Handshake
//  ---------+------------------------------------+-----------------------------------
//  command  | start, busy, i_cmd                 | item taken when start & !busy
//  result   | o_res_valid, o_res                 | one-cycle strobe, no back-pressure
//  config   | i_cfg_we, i_cfg_wdata              | written when i_cfg_we is high
//
// Sequencing: init, deinit, delete, unset, suspend and resume are decoded and
// answered in ST_DEC; set goes on to ST_SADD; create examines the slots in order in ST_CSCAN.
// A tick walks the slots one at a time through the shared adder (ST_TRD, ST_TCMP,
// and ST_TADD for a periodic slot that expires), then ends in ST_TEND.
// Reset is synchronous and clears the flags and control state; the timing
// memory is not cleared, as an entry is only read while its slot is scheduled.
// The receiver cannot stall; results of a tick appear as the scan finds them.
module software_timer_table_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  stt_pkg::t_cmd             i_cmd,
    input  logic                      i_cfg_we,
    input  logic [stt_pkg::CPM_W-1:0] i_cfg_wdata,
    output logic                      o_res_valid,
    output stt_pkg::t_res             o_res
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_SADD  = 3'd2;
    localparam logic [2:0] ST_CSCAN = 3'd3;
    localparam logic [2:0] ST_TRD   = 3'd4;
    localparam logic [2:0] ST_TCMP  = 3'd5;
    localparam logic [2:0] ST_TADD  = 3'd6;
    localparam logic [2:0] ST_TEND  = 3'd7;

    logic [2:0]                       r_state, n_state;
    stt_pkg::t_cmd                    r_cmd;
    logic [stt_pkg::CPM_W-1:0]        r_cpm;
    logic                             r_on, n_on;
    logic [stt_pkg::SLOTS-1:0]        r_live, n_live;
    logic [stt_pkg::SLOTS-1:0]        r_susp, n_susp;
    logic [stt_pkg::SLOTS-1:0]        r_sched, n_sched;
    logic [stt_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic [stt_pkg::CNT_W-1:0]        r_n, n_n;
    logic                             r_pend_v, n_pend_v;
    logic [stt_pkg::IDX_W-1:0]        r_pend_slot, n_pend_slot;
    logic                             r_res_valid, n_res_valid;
    stt_pkg::t_res                    r_res, n_res;

    stt_pkg::t_entry                  r_mem [stt_pkg::SLOTS];
    stt_pkg::t_entry                  r_rd;
    logic                             w_we;
    logic [stt_pkg::IDX_W-1:0]        w_addr;
    stt_pkg::t_entry                  w_wdata;

    stt_pkg::t_alu_ctl                w_ctl;
    logic [63:0]                      w_b, w_prod, w_sum;
    logic                             w_carry;
    logic [stt_pkg::IDX_W-1:0]        w_sidx;
    logic                             w_valid;
    logic                             w_scan;

    assign busy        = (r_state != ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Addressed slot and whether an addressed command is accepted.
    assign w_sidx  = stt_pkg::IDX_W'(r_cmd.slot);
    assign w_valid = r_on && (int'(r_cmd.slot) < stt_pkg::SLOTS);
    assign w_scan  = (r_state == ST_TRD) || (r_state == ST_TCMP) || (r_state == ST_TADD);
    assign w_addr  = w_scan ? r_idx : w_sidx;

    // Shared arithmetic unit.
    stt_arith u_arith (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_ms    (r_cmd.duration_ms),
        .i_cpm   (r_cpm),
        .i_a     (r_cmd.now_cycles),
        .i_b     (w_b),
        .o_prod  (w_prod),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    // Operand selection and memory write for the shared unit.
    always_comb begin
        w_ctl.mul_en = (r_state == ST_DEC);
        w_ctl.sub    = (r_state == ST_TCMP);
        unique case (r_state)
            ST_TCMP: w_b = r_rd.expiration;
            ST_TADD: w_b = r_rd.period;
            default: w_b = w_prod;
        endcase
        w_we    = 1'b0;
        w_wdata = '0;
        if (r_state == ST_SADD) begin
            w_we               = 1'b1;
            w_wdata.expiration = w_sum;
            w_wdata.period     = (r_cmd.opcode == stt_pkg::OP_SET_PER) ? w_prod : 64'd0;
        end else if (r_state == ST_TADD) begin
            w_we               = 1'b1;
            w_wdata.expiration = w_sum;
            w_wdata.period     = r_rd.period;
        end
    end

    // Timing memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rd <= r_mem[w_addr];
    end

    // Sequencer.
    always_comb begin
        logic elig;
        n_state     = r_state;
        n_on        = r_on;
        n_live      = r_live;
        n_susp      = r_susp;
        n_sched     = r_sched;
        n_idx       = r_idx;
        n_n         = r_n;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_res_valid = 1'b0;
        n_res       = '0;
        n_res.kind  = stt_pkg::KIND_REPLY;
        n_res.last  = 1'b1;
        elig        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                n_state = ST_IDLE;
                n_res.ok = w_valid;
                unique case (r_cmd.opcode)
                    stt_pkg::OP_INIT: begin
                        if (!r_on) begin
                            n_live  = '0;
                            n_susp  = '0;
                            n_sched = '0;
                            n_on    = 1'b1;
                        end
                        n_res.ok    = 1'b1;
                        n_res_valid = 1'b1;
                    end
                    stt_pkg::OP_DEINIT: begin
                        n_on        = 1'b0;
                        n_res.ok    = 1'b1;
                        n_res_valid = 1'b1;
                    end
                    stt_pkg::OP_CREATE: begin
                        if (r_on) begin
                            n_idx   = '0;
                            n_state = ST_CSCAN;
                        end else begin
                            n_res.ok    = 1'b0;
                            n_res_valid = 1'b1;
                        end
                    end
                    stt_pkg::OP_DELETE: begin
                        if (w_valid) n_live[w_sidx] = 1'b0;
                        n_res_valid = 1'b1;
                    end
                    stt_pkg::OP_SET, stt_pkg::OP_SET_PER: begin
                        if (w_valid) begin
                            n_state = ST_SADD;
                        end else begin
                            n_res_valid = 1'b1;
                        end
                    end
                    stt_pkg::OP_UNSET: begin
                        if (w_valid) begin
                            n_res.prior_flag = r_sched[w_sidx];
                            n_sched[w_sidx]  = 1'b0;
                        end
                        n_res_valid = 1'b1;
                    end
                    stt_pkg::OP_SUSPEND: begin
                        if (w_valid) begin
                            n_res.prior_flag = r_susp[w_sidx];
                            n_susp[w_sidx]   = 1'b1;
                        end
                        n_res_valid = 1'b1;
                    end
                    stt_pkg::OP_RESUME: begin
                        if (w_valid) n_susp[w_sidx] = r_cmd.resume_flag;
                        n_res_valid = 1'b1;
                    end
                    stt_pkg::OP_TICK: begin
                        if (r_on) begin
                            n_idx    = '0;
                            n_n      = '0;
                            n_pend_v = 1'b0;
                            n_state  = ST_TRD;
                        end else begin
                            n_res.kind  = stt_pkg::KIND_IDLE;
                            n_res.ok    = 1'b0;
                            n_res_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_res.ok    = 1'b0;
                        n_res_valid = 1'b1;
                    end
                endcase
            end
            ST_SADD: begin
                // The memory takes the new expiration in this cycle.
                n_sched[w_sidx] = 1'b1;
                n_res.ok        = 1'b1;
                n_res_valid     = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_CSCAN: begin
                // Walk the slots for the lowest one that is free.
                if (!r_live[r_idx]) begin
                    n_live[r_idx]  = 1'b1;
                    n_susp[r_idx]  = 1'b0;
                    n_sched[r_idx] = 1'b0;
                    n_res.ok       = 1'b1;
                    n_res.slot_out = 4'(r_idx);
                    n_res_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end else if (int'(r_idx) == stt_pkg::SLOTS - 1) begin
                    n_res.ok    = 1'b0;
                    n_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_TRD: begin
                n_state = ST_TCMP;
            end
            ST_TCMP: begin
                // The subtraction carries out when now is at or past expiration.
                elig = r_live[r_idx] && !r_susp[r_idx] && r_sched[r_idx] && w_carry
                       && (r_n < stt_pkg::CNT_W'(stt_pkg::MAX_RESULTS));
                if (elig) begin
                    // An earlier expiry is sent now that it is known not to be the last.
                    if (r_pend_v) begin
                        n_res.kind     = stt_pkg::KIND_EXPIRY;
                        n_res.ok       = 1'b1;
                        n_res.slot_out = 4'(r_pend_slot);
                        n_res.last     = 1'b0;
                        n_res_valid    = 1'b1;
                    end
                    n_pend_v    = 1'b1;
                    n_pend_slot = r_idx;
                    n_n         = r_n + 1'b1;
                end
                if (elig && (|r_rd.period)) begin
                    n_state = ST_TADD;
                end else begin
                    if (elig) n_sched[r_idx] = 1'b0;
                    if (int'(r_idx) == stt_pkg::SLOTS - 1) begin
                        n_state = ST_TEND;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_TRD;
                    end
                end
            end
            ST_TADD: begin
                // Periodic slot: the memory takes now + period in this cycle.
                if (int'(r_idx) == stt_pkg::SLOTS - 1) begin
                    n_state = ST_TEND;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_TRD;
                end
            end
            ST_TEND: begin
                n_res.ok    = 1'b1;
                n_res_valid = 1'b1;
                if (r_pend_v) begin
                    n_res.kind     = stt_pkg::KIND_EXPIRY;
                    n_res.slot_out = 4'(r_pend_slot);
                end else begin
                    n_res.kind = stt_pkg::KIND_IDLE;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cpm       <= stt_pkg::CPM_RESET;
            r_on        <= 1'b0;
            r_live      <= '0;
            r_susp      <= '0;
            r_sched     <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_pend_v    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_on        <= n_on;
            r_live      <= n_live;
            r_susp      <= n_susp;
            r_sched     <= n_sched;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_pend_v    <= n_pend_v;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_cpm <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        r_pend_slot <= n_pend_slot;
        r_res       <= n_res;
    end

    // The last result of an item leaves the block idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |-> !busy)
        else $error("final result shown while the sequencer is still busy");

    // Only expiries of a tick scan come without the last mark.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |-> busy && (o_res.kind == stt_pkg::KIND_EXPIRY))
        else $error("unmarked result outside a tick scan");

    // An accepted item keeps the block busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start the sequencer");

    // An expiry is only reported while the driver is on.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.kind == stt_pkg::KIND_EXPIRY) |-> o_res.ok && r_on)
        else $error("expiry reported with the driver off");

endmodule

/* rtl/core/stt_arith.sv */
// Shared arithmetic unit of the timer table: a registered 32 x 20 multiplier
// and one 64-bit adder/subtractor with carry out.
// Depends on stt_pkg.
module stt_arith (
    input  logic                     i_clk,
    input  stt_pkg::t_alu_ctl        i_ctl,
    input  logic [31:0]              i_ms,
    input  logic [stt_pkg::CPM_W-1:0] i_cpm,
    input  logic [63:0]              i_a,
    input  logic [63:0]              i_b,
    output logic [63:0]              o_prod,
    output logic [63:0]              o_sum,
    output logic                     o_carry
);

    logic [51:0] r_prod;
    logic [63:0] w_b;

    // The duration product is loaded on request and held for the following add.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_ms * i_cpm;
        end
    end

    assign o_prod = 64'(r_prod);

    // Add, or subtract by inverting the second operand; a carry out on a
    // subtraction means a is not below b.
    assign w_b = i_ctl.sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, w_b} + 65'(i_ctl.sub);

endmodule

/* verif/software_timer_table_checker.sv */
`timescale 1ns / 1ps
// Checker for the software timer table: watches the command, configuration and
// result channels, keeps its own copy of the slot table and compares every result item.
// Depends on stt_pkg.
import stt_pkg::*;

module software_timer_table_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [CPM_W-1:0] i_cfg_wdata,
    input  logic             i_res_valid,
    input  t_res             i_res,
    output int               o_errors,
    output int               o_pending
);

    // Shadow copy of the table and its driver state.
    logic             drv_on;
    logic [SLOTS-1:0] live;
    logic [SLOTS-1:0] halted;
    logic [SLOTS-1:0] armed;
    logic [63:0]      expiry [SLOTS];
    logic [63:0]      reload [SLOTS];
    logic [CPM_W-1:0] cpm;

    // Result items still owed by the block, oldest first.
    t_res             owed_results [$];
    int               faults  = 0;
    int               backlog = 0;

    assign o_errors  = faults;
    assign o_pending = backlog;

    // Clears every slot, as reset and a fresh init do.
    task automatic wipe_slots();
        int i;
        live   = '0;
        halted = '0;
        armed  = '0;
        for (i = 0; i < SLOTS; i++) begin
            expiry[i] = '0;
            reload[i] = '0;
        end
    endtask

    // Applies one accepted command item to the shadow table and queues the
    // result items it should produce.
    task automatic apply_command(input t_cmd c);
        logic        accepted;
        logic [63:0] span;
        t_res        r;
        t_res        held;
        int          fired;
        int          i;
        accepted = drv_on && (int'(c.slot) < SLOTS);
        span     = 64'(c.duration_ms) * 64'(cpm);
        r        = '0;
        held     = '0;
        r.kind   = KIND_REPLY;
        r.ok     = accepted;
        r.last   = 1'b1;
        case (c.opcode)
            OP_INIT: begin
                if (!drv_on) begin
                    wipe_slots();
                    drv_on = 1'b1;
                end
                r.ok = 1'b1;
            end
            OP_DEINIT: begin
                drv_on = 1'b0;
                r.ok   = 1'b1;
            end
            OP_CREATE: begin
                // The lowest free slot is taken; a full table or an idle driver refuses.
                r.ok = 1'b0;
                if (drv_on) begin
                    for (i = 0; i < SLOTS; i++) begin
                        if (!live[i] && !r.ok) begin
                            live[i]    = 1'b1;
                            halted[i]  = 1'b0;
                            armed[i]   = 1'b0;
                            r.ok       = 1'b1;
                            r.slot_out = 4'(i);
                        end
                    end
                end
            end
            OP_DELETE: begin
                if (accepted) live[c.slot] = 1'b0;
            end
            OP_SET, OP_SET_PER: begin
                if (accepted) begin
                    expiry[c.slot] = c.now_cycles + span;
                    reload[c.slot] = (c.opcode == OP_SET_PER) ? span : 64'd0;
                    armed[c.slot]  = 1'b1;
                end
            end
            OP_UNSET: begin
                if (accepted) begin
                    r.prior_flag  = armed[c.slot];
                    armed[c.slot] = 1'b0;
                end
            end
            OP_SUSPEND: begin
                if (accepted) begin
                    r.prior_flag   = halted[c.slot];
                    halted[c.slot] = 1'b1;
                end
            end
            OP_RESUME: begin
                if (accepted) halted[c.slot] = c.resume_flag;
            end
            OP_TICK: begin
                // Scan in slot order; each expiry is held back one step so that
                // the final one can carry the last marker.
                fired = 0;
                if (drv_on) begin
                    for (i = 0; i < SLOTS && fired < MAX_RESULTS; i++) begin
                        if (live[i] && !halted[i] && armed[i] && c.now_cycles >= expiry[i]) begin
                            if (reload[i] != 64'd0) expiry[i] = c.now_cycles + reload[i];
                            else armed[i] = 1'b0;
                            if (fired != 0) owed_results.push_back(held);
                            held          = '0;
                            held.kind     = KIND_EXPIRY;
                            held.ok       = 1'b1;
                            held.slot_out = 4'(i);
                            fired++;
                        end
                    end
                end
                if (fired == 0) begin
                    r.kind = KIND_IDLE;
                    r.ok   = drv_on;
                end else begin
                    r      = held;
                    r.last = 1'b1;
                end
            end
            default: begin
                r.ok = 1'b0;
            end
        endcase
        owed_results.push_back(r);
    endtask

    // Reports one field that differs from the prediction.
    task automatic compare_field(input string name, input logic [3:0] want,
                                 input logic [3:0] got);
        if (got !== want) begin
            faults++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Matches an arriving result item with the oldest one owed.
    task automatic check_result(input t_res got);
        t_res want;
        if (owed_results.size() == 0) begin
            faults++;
            $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d/%0d/%0d",
                     $time, got.kind, got.ok, got.slot_out, got.prior_flag, got.last);
        end else begin
            want = owed_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("ok", want.ok, got.ok);
            compare_field("slot_out", want.slot_out, got.slot_out);
            compare_field("prior_flag", want.prior_flag, got.prior_flag);
            compare_field("last", want.last, got.last);
        end
    endtask

    // Results are checked before a new item is taken, as a result seen at the
    // same edge belongs to an earlier item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_slots();
            drv_on = 1'b0;
            cpm    = CPM_RESET;
            owed_results.delete();
        end else begin
            if (i_res_valid) check_result(i_res);
            if (i_cfg_we) cpm = i_cfg_wdata;
            if (i_start && !i_busy) apply_command(i_cmd);
        end
        backlog = owed_results.size();
    end

endmodule

/* verif/software_timer_table_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the software timer table: clock, reset, command and
// configuration stimulus and the verdict. Depends on stt_pkg,
// software_timer_table_top and software_timer_table_checker.
module software_timer_table_top_tb;
    import stt_pkg::*;

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         SEGMENT_ITEMS = 34;
    localparam logic [3:0] OP_UNUSED_LO  = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI  = 4'd15;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    t_cmd             cmd       = '0;
    logic             cfg_we    = 1'b0;
    logic [CPM_W-1:0] cfg_wdata = '0;
    logic             res_valid;
    t_res             res;

    int               errors;
    int               backlog;
    int               cycles    = 0;
    int               gap_pct   = 0;
    logic [63:0]      sim_now   = '0;
    logic [CPM_W-1:0] cpm_now   = CPM_RESET;
    logic [CPM_W-1:0] seg_cpm [6];
    int               seg;

    always #10 clk = ~clk;

    software_timer_table_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (cmd),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    software_timer_table_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (cmd),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_errors    (errors),
        .o_pending   (backlog)
    );

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Fully random fields; also used as the bus content while start is low.
    function automatic t_cmd noise_cmd();
        t_cmd c;
        c.opcode      = 4'($urandom);
        c.slot        = 4'($urandom);
        c.duration_ms = $urandom;
        c.resume_flag = 1'($urandom);
        c.now_cycles  = {$urandom, $urandom};
        return c;
    endfunction

    function automatic t_cmd make_cmd(input logic [3:0] op, input logic [3:0] s,
                                      input logic [31:0] ms, input logic flag,
                                      input logic [63:0] now);
        t_cmd c;
        c.opcode      = op;
        c.slot        = s;
        c.duration_ms = ms;
        c.resume_flag = flag;
        c.now_cycles  = now;
        return c;
    endfunction

    // A weighted random command on a clock that mostly creeps forward in
    // steps of a few milliseconds, so that timers do come due.
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   pick;
        c    = noise_cmd();
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) != 0) c.duration_ms = $urandom_range(0, 12);
        c.resume_flag = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 29) == 0)
            sim_now = {$urandom, $urandom};
        else
            sim_now = sim_now + 64'($urandom_range(0, 6)) * 64'(cpm_now)
                              + 64'($urandom_range(0, 99));
        if      (pick < 3)  c.opcode = OP_INIT;
        else if (pick < 5)  c.opcode = OP_DEINIT;
        else if (pick < 20) c.opcode = OP_CREATE;
        else if (pick < 30) c.opcode = OP_DELETE;
        else if (pick < 45) c.opcode = OP_SET;
        else if (pick < 58) c.opcode = OP_SET_PER;
        else if (pick < 64) c.opcode = OP_UNSET;
        else if (pick < 70) c.opcode = OP_SUSPEND;
        else if (pick < 78) c.opcode = OP_RESUME;
        else if (pick < 97) c.opcode = OP_TICK;
        else c.opcode = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        if (c.opcode == OP_SET || c.opcode == OP_SET_PER || c.opcode == OP_TICK)
            c.now_cycles = sim_now;
        return c;
    endfunction

    // Offers one item, after a random gap, and returns at the edge that takes it.
    task automatic send(input t_cmd c);
        while ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            cmd   <= noise_cmd();
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
    endtask

    // Holds off until every owed result has arrived and the block has gone quiet.
    task automatic settle();
        start <= 1'b0;
        do @(negedge clk); while (backlog != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cpm(input logic [CPM_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cpm_now    = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Fills the table, arms every slot and ticks past them all, so that one
    // tick gives the largest number of expiries.
    task automatic fill_and_fire();
        t_cmd c;
        int   i;
        send(make_cmd(OP_INIT, 4'($urandom), $urandom, 1'b0, sim_now));
        for (i = 0; i <= SLOTS; i++) begin
            c        = noise_cmd();
            c.opcode = OP_CREATE;
            send(c);
        end
        for (i = 0; i < SLOTS; i++) begin
            c = make_cmd($urandom_range(0, 1) ? OP_SET_PER : OP_SET, 4'(i),
                         $urandom_range(0, 3), 1'($urandom), sim_now);
            send(c);
        end
        for (i = 0; i < SLOTS; i++)
            send(make_cmd(OP_RESUME, 4'(i), $urandom, 1'b0, sim_now));
        sim_now = sim_now + 64'(4) * 64'(cpm_now) + 64'd1;
        send(make_cmd(OP_TICK, 4'($urandom), $urandom, 1'b0, sim_now));
    endtask

    initial begin
        seg_cpm = '{20'd0, 20'd1000, 20'hFFFFF, 20'd1000000, 20'd1, 20'd1};
        seg_cpm[4] = CPM_W'($urandom_range(1, 5000));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset rate: driver off, double init, wrap of
        // the expiry sum, zero period, flag histories and an unknown opcode.
        gap_pct = 15;
        send(make_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_CREATE, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_SET, 4'd3, 32'd5, 1'b0, 64'd0));
        send(make_cmd(OP_UNUSED_HI, 4'hF, 32'hFFFF_FFFF, 1'b1, '1));
        send(make_cmd(OP_INIT, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_INIT, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_CREATE, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_CREATE, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_SET, 4'd0, 32'hFFFF_FFFF, 1'b0, '1));
        send(make_cmd(OP_SET_PER, 4'd1, 32'd0, 1'b0, 64'd5));
        send(make_cmd(OP_SET, 4'd15, 32'd1, 1'b0, 64'd0));
        send(make_cmd(OP_SUSPEND, 4'd1, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_SUSPEND, 4'd1, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_RESUME, 4'd1, 32'd0, 1'b1, 64'd0));
        send(make_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, 64'd10));
        send(make_cmd(OP_RESUME, 4'd1, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, '1));
        send(make_cmd(OP_UNSET, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_SET_PER, 4'd0, 32'd2, 1'b0, 64'd0));
        send(make_cmd(OP_UNSET, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_DELETE, 4'd1, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_DELETE, 4'd15, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_DEINIT, 4'd0, 32'd0, 1'b0, 64'd0));
        send(make_cmd(OP_TICK, 4'd0, 32'd0, 1'b0, '1));
        send(make_cmd(OP_SET, 4'd2, 32'd1, 1'b0, 64'd0));
        send(make_cmd(OP_INIT, 4'd0, 32'd0, 1'b0, 64'd0));

        // Random segments, each at its own rate, with gaps shared by pairs of segments;
        // the owed results are drained before every rate change.
        for (seg = 0; seg < 6; seg++) begin
            gap_pct = (seg < 2) ? 15 : ((seg < 4) ? 84 : 0);
            write_cpm(seg_cpm[seg]);
            sim_now = {$urandom, $urandom} >> $urandom_range(8, 40);
            if (seg % 2 == 1) fill_and_fire();
            repeat (SEGMENT_ITEMS) send(random_cmd());
        end

        settle();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
